>>> hdl/ect_pkg.sv
`timescale 1ns / 1ps
// Package for the epoch checkpoint table: constants, codes and the
// structs shared by all modules. No dependencies.
package ect_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned DATA_W = 64;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [DATA_W-1:0] MAX_U64 = '1;
  localparam logic [DATA_W-1:0] WARN_RESET = 64'd3600000000000;
  localparam logic [DATA_W-1:0] REJECT_RESET = 64'd86400000000000;

  localparam logic [CFG_IDX_W-1:0] REG_WARN_AGE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REJECT_AGE = 1'b1;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic ST_OK = 1'b0;
  localparam logic ST_MISS = 1'b1;

  typedef enum logic [1:0] {
    STALE_FRESH,
    STALE_WARN,
    STALE_REJECT
  } stale_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND,
    S_MIN,
    S_WRITE,
    S_TOP,
    S_AGE,
    S_REJ,
    S_WARN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic              op;
    logic [DATA_W-1:0] entry_epoch;
    logic [DATA_W-1:0] entry_time;
    logic [DATA_W-1:0] entry_log_size;
    logic [DATA_W-1:0] now;
  } in_t;

  typedef struct packed {
    logic              status;
    logic [DATA_W-1:0] found_time;
    logic [DATA_W-1:0] found_log_size;
    logic [DATA_W-1:0] latest_seen_epoch;
    logic [1:0]        staleness;
  } out_t;

  typedef struct packed {
    logic [DATA_W-1:0] epoch;
    logic [DATA_W-1:0] ts;
    logic [DATA_W-1:0] size;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } mem_wr_t;

  typedef struct packed {
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } cmp_req_t;

  typedef struct packed {
    logic              eq;
    logic              lt;
    logic [DATA_W-1:0] diff;
  } cmp_rsp_t;

  typedef struct packed {
    logic [DATA_W-1:0] warn_age_ns;
    logic [DATA_W-1:0] reject_age_ns;
  } cfg_t;

endpackage

>>> hdl/epoch_checkpoint_table.sv
`timescale 1ns / 1ps
// Epoch checkpoint table top level: config registers, store, compare unit
// and sequencer. Depends on ect_pkg, ect_store, ect_alu, ect_seq.
// Each operation scans the table; an insert into a full table also scans for
// the smallest epoch to evict.
// One item at a time: next start is taken in the cycle after done_o; receiver cannot stall.
// Reset (async, low) empties the table, zeroes latest epoch, loads thresholds.
module epoch_checkpoint_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  ect_pkg::in_t                  in_i,
  output logic                          done_o,
  output ect_pkg::out_t                 res_o,
  input  logic                          cfg_we_i,
  input  logic [ect_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ect_pkg::DATA_W-1:0]    cfg_wdata_i
);
  import ect_pkg::*;

  cfg_t     cfg_q;
  cmp_req_t cmp_req;
  cmp_rsp_t cmp_rsp;
  mem_wr_t  wr;
  logic [IDX_W-1:0] raddr;
  entry_t   rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.warn_age_ns   <= WARN_RESET;
      cfg_q.reject_age_ns <= REJECT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WARN_AGE:   cfg_q.warn_age_ns <= cfg_wdata_i;
        REG_REJECT_AGE: cfg_q.reject_age_ns <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  ect_store u_store (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .raddr_i (raddr),
    .rd_o    (rd)
  );

  ect_alu u_alu (
    .req_i (cmp_req),
    .rsp_o (cmp_rsp)
  );

  ect_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .in_i      (in_i),
    .done_o    (done_o),
    .res_o     (res_o),
    .cfg_i     (cfg_q),
    .cmp_req_o (cmp_req),
    .cmp_rsp_i (cmp_rsp),
    .wr_o      (wr),
    .raddr_o   (raddr),
    .rd_i      (rd)
  );

endmodule

>>> hdl/ect_store.sv
`timescale 1ns / 1ps
// Checkpoint storage: one write port, one read port with registered data.
// Depends on ect_pkg.
module ect_store (
  input  logic                  clk_i,
  input  ect_pkg::mem_wr_t      wr_i,
  input  logic [ect_pkg::IDX_W-1:0] raddr_i,
  output ect_pkg::entry_t       rd_o
);
  import ect_pkg::*;

  entry_t mem_q [TABLE_DEPTH];
  entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[raddr_i];
  end

  assign rd_o = rd_q;

endmodule

>>> hdl/ect_alu.sv
`timescale 1ns / 1ps
// Shared 64-bit compare and subtract unit: a == b, a < b, a - b.
// Depends on ect_pkg.
module ect_alu (
  input  ect_pkg::cmp_req_t req_i,
  output ect_pkg::cmp_rsp_t rsp_o
);
  import ect_pkg::*;

  logic [DATA_W:0] sub;

  assign sub = {1'b0, req_i.a} - {1'b0, req_i.b};

  assign rsp_o.eq = (req_i.a == req_i.b);
  assign rsp_o.lt = sub[DATA_W];
  assign rsp_o.diff = sub[DATA_W-1:0];

endmodule

>>> hdl/ect_seq.sv
`timescale 1ns / 1ps
// Sequencer for the checkpoint table: table scans, insert, age and class.
// Drives the shared compare unit and the store. Depends on ect_pkg.
module ect_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  ect_pkg::in_t        in_i,
  output logic                done_o,
  output ect_pkg::out_t       res_o,
  input  ect_pkg::cfg_t       cfg_i,
  output ect_pkg::cmp_req_t   cmp_req_o,
  input  ect_pkg::cmp_rsp_t   cmp_rsp_i,
  output ect_pkg::mem_wr_t    wr_o,
  output logic [ect_pkg::IDX_W-1:0] raddr_o,
  input  ect_pkg::entry_t     rd_i
);
  import ect_pkg::*;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic              pend_q, pend_d;
  logic [IDX_W-1:0]  pidx_q, pidx_d;
  logic [CNT_W-1:0]  used_q, used_d;
  logic [DATA_W-1:0] top_q, top_d;
  in_t               inp_q, inp_d;
  logic [IDX_W-1:0]  slot_q, slot_d;
  logic              hit_q, hit_d;
  logic [DATA_W-1:0] low_q, low_d;
  logic [DATA_W-1:0] ftime_q, ftime_d;
  logic [DATA_W-1:0] fsize_q, fsize_d;
  logic [DATA_W-1:0] tage_q, tage_d;
  logic [DATA_W-1:0] age_q, age_d;
  stale_e            class_q, class_d;
  logic              scan_issue;
  logic              scan_end;
  logic              find_hit;
  logic              find_over;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      pend_q  <= 1'b0;
      used_q  <= '0;
      top_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      used_q  <= used_d;
      top_q   <= top_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q  <= pidx_d;
    inp_q   <= inp_d;
    slot_q  <= slot_d;
    hit_q   <= hit_d;
    low_q   <= low_d;
    ftime_q <= ftime_d;
    fsize_q <= fsize_d;
    tage_q  <= tage_d;
    age_q   <= age_d;
    class_q <= class_d;
  end

  assign scan_issue = (idx_q < used_q);
  assign scan_end = !pend_q && !scan_issue;
  assign raddr_o = idx_q[IDX_W-1:0];

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    pend_d    = pend_q;
    pidx_d    = pidx_q;
    used_d    = used_q;
    top_d     = top_q;
    inp_d     = inp_q;
    slot_d    = slot_q;
    hit_d     = hit_q;
    low_d     = low_q;
    ftime_d   = ftime_q;
    fsize_d   = fsize_q;
    tage_d    = tage_q;
    age_d     = age_q;
    class_d   = class_q;
    cmp_req_o = '{a: rd_i.epoch, b: inp_q.entry_epoch};
    wr_o      = '{en: 1'b0, addr: slot_q,
                  data: '{epoch: inp_q.entry_epoch, ts: inp_q.entry_time,
                          size: inp_q.entry_log_size}};
    find_hit  = 1'b0;
    find_over = 1'b0;

    if (state_q == S_FIND || state_q == S_MIN || state_q == S_TOP) begin
      if (scan_issue) begin
        idx_d  = idx_q + CNT_W'(1);
        pend_d = 1'b1;
        pidx_d = idx_q[IDX_W-1:0];
      end else begin
        pend_d = 1'b0;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (start) begin
          inp_d   = in_i;
          idx_d   = '0;
          pend_d  = 1'b0;
          hit_d   = 1'b0;
          ftime_d = '0;
          fsize_d = '0;
          state_d = S_FIND;
        end
      end
      S_FIND: begin
        if (pend_q && cmp_rsp_i.eq) begin
          find_hit  = 1'b1;
          find_over = 1'b1;
          hit_d     = 1'b1;
          slot_d    = pidx_q;
          if (inp_q.op == OP_LOOKUP) begin
            ftime_d = rd_i.ts;
            fsize_d = rd_i.size;
          end
        end else if (scan_end) begin
          find_over = 1'b1;
        end
        if (find_over) begin
          idx_d  = '0;
          pend_d = 1'b0;
          if (inp_q.op == OP_LOOKUP) begin
            state_d = S_TOP;
          end else if (find_hit) begin
            state_d = S_WRITE;
          end else if (used_q != CNT_W'(TABLE_DEPTH)) begin
            slot_d  = used_q[IDX_W-1:0];
            used_d  = used_q + CNT_W'(1);
            state_d = S_WRITE;
          end else begin
            low_d   = MAX_U64;
            slot_d  = '0;
            state_d = S_MIN;
          end
        end
      end
      S_MIN: begin
        cmp_req_o = '{a: rd_i.epoch, b: low_q};
        if (pend_q && cmp_rsp_i.lt) begin
          low_d  = rd_i.epoch;
          slot_d = pidx_q;
        end
        if (scan_end) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        wr_o.en   = 1'b1;
        cmp_req_o = '{a: top_q, b: inp_q.entry_epoch};
        if (cmp_rsp_i.lt) begin
          top_d = inp_q.entry_epoch;
        end
        idx_d   = '0;
        pend_d  = 1'b0;
        state_d = S_TOP;
      end
      S_TOP: begin
        cmp_req_o = '{a: rd_i.epoch, b: top_q};
        if (pend_q && cmp_rsp_i.eq) begin
          tage_d  = rd_i.ts;
          pend_d  = 1'b0;
          state_d = S_AGE;
        end else if (scan_end) begin
          age_d   = '0;
          state_d = S_REJ;
        end
      end
      S_AGE: begin
        cmp_req_o = '{a: inp_q.now, b: tage_q};
        age_d = (!cmp_rsp_i.lt && !cmp_rsp_i.eq) ? cmp_rsp_i.diff : '0;
        state_d = S_REJ;
      end
      S_REJ: begin
        cmp_req_o = '{a: age_q, b: cfg_i.reject_age_ns};
        if (used_q == '0 || !cmp_rsp_i.lt) begin
          class_d = STALE_REJECT;
          state_d = S_DONE;
        end else begin
          state_d = S_WARN;
        end
      end
      S_WARN: begin
        cmp_req_o = '{a: age_q, b: cfg_i.warn_age_ns};
        class_d = cmp_rsp_i.lt ? STALE_FRESH : STALE_WARN;
        state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);
  assign res_o = '{
    status:            (inp_q.op == OP_LOOKUP && !hit_q) ? ST_MISS : ST_OK,
    found_time:        ftime_q,
    found_log_size:    fsize_q,
    latest_seen_epoch: top_q,
    staleness:         class_q
  };

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(TABLE_DEPTH))
    else $error("used count past table depth");

  a_start_find: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && state_q == S_IDLE) |=> (state_q == S_FIND))
    else $error("accepted transfer did not start a scan");

  a_done_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_o) |-> ($past(state_q) == S_REJ || $past(state_q) == S_WARN))
    else $error("result strobe without staleness step");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("result strobe longer than one cycle");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status == ST_MISS) |-> (ftime_q == '0 && fsize_q == '0))
    else $error("miss carries entry data");

  a_top_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q >= $past(top_q))
    else $error("latest epoch decreased");

endmodule

>>> tb/epoch_checkpoint_table_tb.sv
`timescale 1ns / 1ps
// Testbench for epoch_checkpoint_table: directed table, then random phases
// checked against a behavioral checkpoint-table predictor. Depends on ect_pkg.
module epoch_checkpoint_table_tb;
  import ect_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int NUM_PHASES = 7;
  localparam int ITEMS_PER_PHASE = 157;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  in_t                  in_i = '0;
  logic                 done_o;
  out_t                 res_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [DATA_W-1:0]    cfg_wdata_i = '0;

  epoch_checkpoint_table dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_i       (in_i),
    .done_o     (done_o),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  logic [DATA_W-1:0] ckpt_epoch [TABLE_DEPTH];
  logic [DATA_W-1:0] ckpt_time  [TABLE_DEPTH];
  logic [DATA_W-1:0] ckpt_size  [TABLE_DEPTH];
  int                ckpt_count = 0;
  logic [DATA_W-1:0] newest_epoch = '0;
  logic [DATA_W-1:0] warn_limit = WARN_RESET;
  logic [DATA_W-1:0] reject_limit = REJECT_RESET;

  out_t pending_results [$];
  int   err_count = 0;
  int   cycle_count = 0;

  typedef struct {
    in_t  item;
    bit   typed;
    out_t res;
  } dir_row_t;

  dir_row_t dir_rows [$];

  task automatic report_mismatch(string msg);
    err_count++;
    if (err_count <= 40) $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  function automatic int find_slot(logic [DATA_W-1:0] key);
    for (int i = 0; i < ckpt_count; i++) begin
      if (ckpt_epoch[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic out_t predict_result(in_t it);
    out_t              r;
    int                s;
    logic [DATA_W-1:0] age;
    r = '0;
    age = '0;
    s = find_slot(it.entry_epoch);
    if (it.op == OP_INSERT) begin
      if (s < 0) begin
        if (ckpt_count >= TABLE_DEPTH) begin
          // evict smallest epoch, lowest index on a tie
          s = 0;
          for (int i = 1; i < TABLE_DEPTH; i++) begin
            if (ckpt_epoch[i] < ckpt_epoch[s]) s = i;
          end
        end else begin
          s = ckpt_count;
          ckpt_count++;
        end
      end
      ckpt_epoch[s] = it.entry_epoch;
      ckpt_time[s] = it.entry_time;
      ckpt_size[s] = it.entry_log_size;
      if (it.entry_epoch > newest_epoch) newest_epoch = it.entry_epoch;
    end else if (s >= 0) begin
      r.found_time = ckpt_time[s];
      r.found_log_size = ckpt_size[s];
    end else begin
      r.status = ST_MISS;
    end
    r.latest_seen_epoch = newest_epoch;
    s = find_slot(newest_epoch);
    if (s >= 0 && it.now > ckpt_time[s]) age = it.now - ckpt_time[s];
    if (ckpt_count == 0 || age >= reject_limit) r.staleness = STALE_REJECT;
    else if (age >= warn_limit) r.staleness = STALE_WARN;
    else r.staleness = STALE_FRESH;
    return r;
  endfunction

  function automatic void add_row(logic op, logic [DATA_W-1:0] ep, logic [DATA_W-1:0] tm,
                                  logic [DATA_W-1:0] sz, logic [DATA_W-1:0] nw,
                                  bit typed = 1'b0, logic st = ST_OK,
                                  logic [DATA_W-1:0] ft = '0, logic [DATA_W-1:0] fs = '0,
                                  logic [DATA_W-1:0] lat = '0, stale_e sc = STALE_FRESH);
    dir_row_t r;
    r.item = {op, ep, tm, sz, nw};
    r.typed = typed;
    r.res = {st, ft, fs, lat, sc};
    dir_rows.push_back(r);
  endfunction

  // start is raised at the current edge and held until the transfer
  task automatic send_item(in_t it, bit typed, out_t typed_res);
    out_t predicted;
    start <= 1'b1;
    in_i <= it;
    do @(posedge clk_i); while (busy !== 1'b0);
    predicted = predict_result(it);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic wait_idle();
    while (pending_results.size() != 0 || busy !== 1'b0) @(posedge clk_i);
  endtask

  task automatic set_limits(logic [DATA_W-1:0] warn, logic [DATA_W-1:0] rej);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_WARN_AGE;
    cfg_wdata_i <= warn;
    @(posedge clk_i);
    cfg_idx_i <= REG_REJECT_AGE;
    cfg_wdata_i <= rej;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    warn_limit = warn;
    reject_limit = rej;
  endtask

  always @(posedge clk_i) begin : result_check
    out_t want;
    if (rst_ni && done_o !== 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (res_o.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", res_o.status, want.status));
        if (res_o.found_time !== want.found_time)
          report_mismatch($sformatf("found_time got %h want %h",
                                    res_o.found_time, want.found_time));
        if (res_o.found_log_size !== want.found_log_size)
          report_mismatch($sformatf("found_log_size got %h want %h",
                                    res_o.found_log_size, want.found_log_size));
        if (res_o.latest_seen_epoch !== want.latest_seen_epoch)
          report_mismatch($sformatf("latest_seen_epoch got %h want %h",
                                    res_o.latest_seen_epoch, want.latest_seen_epoch));
        if (res_o.staleness !== want.staleness)
          report_mismatch($sformatf("staleness got %0d want %0d",
                                    res_o.staleness, want.staleness));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    in_t               it;
    logic [DATA_W-1:0] warn_set [NUM_PHASES];
    logic [DATA_W-1:0] rej_set [NUM_PHASES];
    int                idle_set [NUM_PHASES];
    logic [DATA_W-1:0] epoch_cur;
    logic [DATA_W-1:0] time_cur;
    logic [DATA_W-1:0] wide;
    logic [DATA_W-1:0] base;
    int                sel;
    int                s;

    // empty table, then boundaries of the reset thresholds
    add_row(OP_LOOKUP, 0, 0, 0, 0, 1, ST_MISS, 0, 0, 0, STALE_REJECT);
    add_row(OP_LOOKUP, MAX_U64, MAX_U64, MAX_U64, MAX_U64,
            1, ST_MISS, 0, 0, 0, STALE_REJECT);
    add_row(OP_INSERT, 5, 1000, 7, 1000, 1, ST_OK, 0, 0, 5, STALE_FRESH);
    add_row(OP_LOOKUP, 5, 0, 0, 999, 1, ST_OK, 1000, 7, 5, STALE_FRESH);
    add_row(OP_LOOKUP, 5, 0, 0, 1000 + WARN_RESET - 1, 1, ST_OK, 1000, 7, 5, STALE_FRESH);
    add_row(OP_LOOKUP, 5, 0, 0, 1000 + WARN_RESET, 1, ST_OK, 1000, 7, 5, STALE_WARN);
    add_row(OP_LOOKUP, 5, 0, 0, 1000 + REJECT_RESET - 1, 1, ST_OK, 1000, 7, 5, STALE_WARN);
    add_row(OP_LOOKUP, 5, 0, 0, 1000 + REJECT_RESET, 1, ST_OK, 1000, 7, 5, STALE_REJECT);
    // lower epoch leaves latest alone; overwrite of the latest entry
    add_row(OP_INSERT, 3, 0, MAX_U64, MAX_U64, 1, ST_OK, 0, 0, 5, STALE_REJECT);
    add_row(OP_INSERT, 5, MAX_U64, 0, MAX_U64, 1, ST_OK, 0, 0, 5, STALE_FRESH);
    add_row(OP_LOOKUP, 5, 0, 0, 0, 1, ST_OK, MAX_U64, 0, 5, STALE_FRESH);
    add_row(OP_LOOKUP, 4, 0, 0, 0, 1, ST_MISS, 0, 0, 5, STALE_FRESH);
    add_row(OP_INSERT, 0, 0, 0, 0, 1, ST_OK, 0, 0, 5, STALE_FRESH);
    // fill the table, then force an eviction of the smallest epoch
    for (int e = 10; e <= 22; e++) add_row(OP_INSERT, e, 2000 + e, e, {$urandom, $urandom});
    add_row(OP_INSERT, 100, 5000, 100, 5000);
    add_row(OP_LOOKUP, 0, 0, 0, 0, 1, ST_MISS, 0, 0, 100, STALE_FRESH);
    add_row(OP_LOOKUP, 3, 0, 0, 4000);

    warn_set = '{WARN_RESET, 64'd1000, 64'd0, 64'd5000, MAX_U64, 64'd0, WARN_RESET};
    rej_set  = '{REJECT_RESET, 64'd5000, 64'd0, 64'd1000, MAX_U64, 64'd0, REJECT_RESET};
    idle_set = '{0, 67, 0, 32, 67, 32, 0};
    warn_set[5] = $urandom_range(0, 100000);
    rej_set[5] = $urandom_range(0, 100000);
    epoch_cur = 200;
    wide = {$urandom, $urandom};
    time_cur = {2'b00, wide[DATA_W-1:2]};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        wait_idle();
        set_limits(warn_set[p], rej_set[p]);
      end
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        it.op = ($urandom_range(0, 99) < 45) ? OP_INSERT : OP_LOOKUP;
        wide = {$urandom, $urandom};
        sel = $urandom_range(0, 99);
        if (it.op == OP_INSERT) begin
          // a huge epoch pins the latest epoch, so only the last phase uses them
          if (p == NUM_PHASES - 1 && sel < 12) it.entry_epoch = (sel < 2) ? MAX_U64 : wide;
          else if (sel < 25) it.entry_epoch = epoch_cur - $urandom_range(0, 40);
          else begin
            epoch_cur = epoch_cur + $urandom_range(0, 2);
            it.entry_epoch = epoch_cur;
          end
        end else begin
          if (sel < 60 && ckpt_count > 0)
            it.entry_epoch = ckpt_epoch[$urandom_range(0, ckpt_count - 1)];
          else if (sel < 80) it.entry_epoch = epoch_cur - $urandom_range(0, 40);
          else if (sel < 97) it.entry_epoch = wide;
          else it.entry_epoch = sel[0] ? MAX_U64 : '0;
        end
        time_cur = time_cur + $urandom_range(0, 5000);
        it.entry_time = ($urandom_range(0, 99) < 20) ? {$urandom, $urandom} : time_cur;
        it.entry_log_size = {$urandom, $urandom};
        // aim 'now' at the thresholds around the latest entry's timestamp
        s = find_slot(newest_epoch);
        base = (s >= 0) ? ckpt_time[s] : time_cur;
        case ($urandom_range(0, 9))
          0: it.now = base + warn_limit - 1;
          1: it.now = base + warn_limit;
          2: it.now = base + reject_limit - 1;
          3: it.now = base + reject_limit;
          4, 5: it.now = base + $urandom_range(0, 20000);
          6: it.now = base - $urandom_range(0, 100);
          7: it.now = {$urandom, $urandom};
          8: it.now = $urandom_range(0, 1) ? MAX_U64 : '0;
          default: it.now = base + {$urandom_range(0, 1000), $urandom};
        endcase
        send_item(it, 1'b0, '0);
        if ($urandom_range(0, 99) < idle_set[p]) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 60)) @(posedge clk_i);
        end
      end
      start <= 1'b0;
    end

    wait_idle();
    repeat (80) @(posedge clk_i);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
